// ===== hw/rtl/mdd_pkg.sv =====
// Shared constants and types for the max drawdown tracker.
`timescale 1ns / 1ps

package mdd_pkg;

  localparam int SAMPLE_BITS_DEF = 32;
  localparam int SUM_BITS_DEF    = 48;
  localparam int DRAWDOWN_BITS   = 48;
  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NAV_INPUT = 1'b0,
    CFG_PEAK_MODE = 1'b1
  } cfg_idx_t;

endpackage

// ===== hw/rtl/mdd_in_if.sv =====
// Input word channel: one sample and its last flag.
`timescale 1ns / 1ps

interface mdd_in_if #(
  parameter int SAMPLE_BITS = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== hw/rtl/mdd_out_if.sv =====
// Result word channel: drawdown and status flags.
`timescale 1ns / 1ps

interface mdd_out_if import mdd_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic signed [DRAWDOWN_BITS-1:0] drawdown;
  logic                            valid_res;
  logic                            error;
  logic                            done_res;

  modport source (output valid, output drawdown, output valid_res, output error,
                  output done_res, input ready);
  modport sink   (input valid, input drawdown, input valid_res, input error,
                  input done_res, output ready);
endinterface

// ===== hw/rtl/max_drawdown_tracker.sv =====
// Max drawdown tracker top level: input register, update logic, result register.
// A word is held in the input register, and its result in the result register.
// Throughput: one word per cycle unless the output stalls; update is combinational.
// Reset: synchronous, active low; clears config, series state and both valid flags.
// Series state also returns to zero after each word with last set.
`timescale 1ns / 1ps

module max_drawdown_tracker import mdd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = SUM_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  mdd_in_if.sink                   in_ch,
  mdd_out_if.source                out_ch
);

  localparam int EW0 = (SAMPLE_BITS + 1 > SUM_BITS) ? SAMPLE_BITS + 1 : SUM_BITS;
  localparam int EW  = EW0 + 1;

  function automatic logic signed [EW-1:0] sx_s(input logic signed [SAMPLE_BITS-1:0] v);
    return {{(EW-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
  endfunction

  function automatic logic signed [EW-1:0] sx_m(input logic signed [SUM_BITS-1:0] v);
    return {{(EW-SUM_BITS){v[SUM_BITS-1]}}, v};
  endfunction

  // saturate to the signed sum range
  function automatic logic signed [SUM_BITS-1:0] sat_f(input logic signed [EW-1:0] v);
    logic [EW-SUM_BITS:0] top;
    top = v[EW-1:SUM_BITS-1];
    if ((&top) || !(|top)) return v[SUM_BITS-1:0];
    else if (v[EW-1]) return {1'b1, {(SUM_BITS-1){1'b0}}};
    else return {1'b0, {(SUM_BITS-1){1'b1}}};
  endfunction

  // config
  logic nav_r, peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nav_r  <= 1'b0;
      peak_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_NAV_INPUT: nav_r  <= cfg_data[0];
        CFG_PEAK_MODE: peak_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_r, out_valid_r;
  logic adv;

  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign out_ch.valid = out_valid_r;

  // input register
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_sample_r <= in_ch.sample;
      s1_last_r   <= in_ch.last;
    end
  end

  // series state
  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic signed [SAMPLE_BITS-1:0] peak_val_r, peak_val_nxt;
  logic signed [SUM_BITS-1:0]    run_r, run_nxt;
  logic signed [SUM_BITS-1:0]    worst_r, worst_nxt;
  logic [1:0]                    seen_r, seen_nxt;

  logic                          err, vres;
  logic signed [SUM_BITS-1:0]    result;
  logic signed [SAMPLE_BITS-1:0] pk;
  logic signed [SUM_BITS-1:0]    dd, wc, rs;
  logic                          have, first;

  always_comb begin
    prev_nxt     = prev_r;
    peak_val_nxt = peak_val_r;
    run_nxt      = run_r;
    worst_nxt    = worst_r;
    seen_nxt     = seen_r;
    err          = peak_r && !nav_r;
    vres         = 1'b0;
    result       = '0;
    pk           = (s1_sample_r > peak_val_r) ? s1_sample_r : peak_val_r;
    dd           = sat_f(sx_s(pk) - sx_s(s1_sample_r));
    wc           = nav_r ? sat_f(sx_s(s1_sample_r) - sx_s(prev_r)) : sat_f(sx_s(s1_sample_r));
    rs           = sat_f(sx_m(run_r) + sx_m(wc));
    have         = !nav_r || (seen_r != 2'd0);
    first        = nav_r ? (seen_r == 2'd1) : (seen_r == 2'd0);

    if (!err) begin
      if (peak_r) begin
        if (seen_r == 2'd0) begin
          peak_val_nxt = s1_sample_r;
          worst_nxt    = '0;
        end else begin
          peak_val_nxt = pk;
          if (dd > worst_r) worst_nxt = dd;
        end
        vres = 1'b1;
      end else begin
        if (have) begin
          if (first) begin
            run_nxt   = wc;
            worst_nxt = wc;
          end else if (wc[SUM_BITS-1]) begin
            run_nxt = rs;
            if (rs < worst_r) worst_nxt = rs;
          end else begin
            run_nxt = '0;
          end
        end
        vres = nav_r ? (seen_r != 2'd0) : 1'b1;
      end
      prev_nxt = s1_sample_r;
      if (seen_r != 2'd2) seen_nxt = seen_r + 2'd1;
      result = worst_nxt;
    end

    if (s1_last_r) begin
      prev_nxt     = '0;
      peak_val_nxt = '0;
      run_nxt      = '0;
      worst_nxt    = '0;
      seen_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      peak_val_r <= '0;
      run_r      <= '0;
      worst_r    <= '0;
      seen_r     <= '0;
    end else if (adv) begin
      prev_r     <= prev_nxt;
      peak_val_r <= peak_val_nxt;
      run_r      <= run_nxt;
      worst_r    <= worst_nxt;
      seen_r     <= seen_nxt;
    end
  end

  // result register
  logic signed [DRAWDOWN_BITS-1:0] dd_out;
  logic signed [DRAWDOWN_BITS-1:0] dd_r;
  logic                            vres_r, err_r, done_r;

  generate
    if (SUM_BITS >= DRAWDOWN_BITS) begin : g_trunc
      assign dd_out = result[DRAWDOWN_BITS-1:0];
    end else begin : g_ext
      assign dd_out = {{(DRAWDOWN_BITS-SUM_BITS){result[SUM_BITS-1]}}, result};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dd_r   <= dd_out;
      vres_r <= vres;
      err_r  <= err;
      done_r <= s1_last_r;
    end
  end

  assign out_ch.drawdown  = dd_r;
  assign out_ch.valid_res = vres_r;
  assign out_ch.error     = err_r;
  assign out_ch.done_res  = done_r;

endmodule
